@@ rtl/rxya_pkg.sv @@
`timescale 1ns / 1ps
package rxya_pkg;

   // Number of recognized plane-angle units; codes at or above it are invalid.
   localparam int UNIT_COUNT = 14;

   // Per-unit description: radian based, multiplier and divisor of the turn count.
   localparam logic UNIT_RADIAN [UNIT_COUNT] = '{
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1
   };
   localparam logic [31:0] UNIT_MUL [UNIT_COUNT] = '{
      32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1000,
      32'd1, 32'd1, 32'd1000000, 32'd1, 32'd1, 32'd1, 32'd1
   };
   localparam logic [31:0] UNIT_DIV [UNIT_COUNT] = '{
      32'd1, 32'd1296000000, 32'd4000000, 32'd40000, 32'd360, 32'd400, 32'd1,
      32'd6400, 32'd21600, 32'd1, 32'd1000, 32'd1, 32'd1296000, 32'd1000000
   };

   // 1/(2*pi) in Q0.192.
   localparam logic [191:0] INV_TWO_PI =
      192'h28BE60DB9391054A7F09D5F47D4D377036D8A5664F10E410;

   // Item handed from the front end to the rotation pipeline.
   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic [63:0]        z;
      logic               err;
   } item_type;

   // Restoring long division of a wide value by a 32-bit value.
   function automatic logic [223:0] div_wide(input logic [223:0] n, input logic [31:0] d);
      logic [223:0] q;
      logic [32:0]  r;
      q = '0;
      r = '0;
      for (int b = 223; b >= 0; b--) begin
         r = {r[31:0], n[b]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Restoring long division of 64-bit values.
   function automatic logic [63:0] div64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Fraction of a turn per angle LSB for one unit, Q0.128, rounded to nearest.
   function automatic logic [127:0] unit_k(input int u);
      logic [223:0] n;
      logic [223:0] q;
      if (UNIT_RADIAN[u]) begin
         n = 224'(INV_TWO_PI) * 224'(UNIT_MUL[u]);
      end else begin
         n = 224'(UNIT_MUL[u]) << 192;
      end
      q = div_wide(n, UNIT_DIV[u]);
      return q[207:80] + 128'(q[79]);
   endfunction

   localparam logic [127:0] UNIT_K [UNIT_COUNT] = '{
      unit_k(0), unit_k(1), unit_k(2), unit_k(3), unit_k(4), unit_k(5), unit_k(6),
      unit_k(7), unit_k(8), unit_k(9), unit_k(10), unit_k(11), unit_k(12), unit_k(13)
   };

   // Micro-rotation angle atan(2^-i) in Q0.64 turns.
   function automatic logic [63:0] atan_turns(input int i);
      logic [63:0]  sum;
      logic [63:0]  term;
      logic [127:0] p;
      sum = '0;
      if (i == 0) begin
         return 64'h2000_0000_0000_0000;
      end
      for (int k = 0; i * (2 * k + 1) < 64; k++) begin
         term = div64(64'd1 << (64 - i * (2 * k + 1)), 64'(2 * k + 1));
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      p = 128'(sum) * 128'(64'h28BE60DB9391054A);
      return p[127:64];
   endfunction

   // Inverse CORDIC gain over the given number of stages, Q0.32.
   function automatic logic [31:0] inv_gain(input int stages);
      logic [63:0]  g;
      logic [63:0]  c;
      logic [63:0]  t;
      logic [127:0] p;
      g = 64'd1 << 62;
      c = '0;
      for (int i = 0; i < stages; i++) begin
         g = g + (g >> (2 * i));
      end
      for (int b = 31; b >= 0; b--) begin
         t = c | (64'd1 << b);
         p = 128'(t * t) * 128'(g);
         if (p[127:64] < (64'd1 << 62)) begin
            c = t;
         end
      end
      return c[31:0];
   endfunction

endpackage

@@ rtl/rxya_front.sv @@
`timescale 1ns / 1ps
module rxya_front #(
   parameter int CORDIC_STAGES = 24,
   parameter int PHASE_BITS    = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic signed [31:0]   x_in,
   input  logic signed [31:0]   y_in,
   input  logic signed [47:0]   angle,
   input  logic [3:0]           unit,
   output logic                 push,
   output rxya_pkg::item_type   item
);
   import rxya_pkg::*;

   localparam logic [31:0] INV_GAIN   = inv_gain(CORDIC_STAGES);
   localparam logic [63:0] PHASE_HALF = 64'd1 << (63 - PHASE_BITS);
   localparam logic [63:0] PHASE_MASK = ~((64'd1 << (64 - PHASE_BITS)) - 64'd1);

   // Stage 0: captured item and selected unit constant.
   logic               v0_ff;
   logic signed [47:0] ang0_ff;
   logic signed [31:0] x0_ff, y0_ff;
   logic [127:0]       k0_ff;
   logic               err0_ff;

   // Stage 1: partial products.
   logic               v1_ff;
   logic [127:0]       pp_ff [8];
   logic [127:0]       pp_in [8];
   logic signed [63:0] xp1_ff, yp1_ff;
   logic               err1_ff;

   // Stage 2 and 3: adder tree.
   logic               v2_ff, v3_ff;
   logic [127:0]       sum4_ff [4];
   logic [127:0]       sum2_ff [2];
   logic signed [63:0] x2_ff, y2_ff, x3_ff, y3_ff;
   logic               err2_ff, err3_ff;

   // Stage 4: rounded phase.
   logic               v4_ff;
   logic [63:0]        z4_ff;
   logic signed [63:0] x4_ff, y4_ff;
   logic               err4_ff;
   logic [127:0]       prod;
   logic [63:0]        phase_rnd;

   // Stage 5: quadrant fold.
   logic               v5_ff;
   item_type           item_ff;
   logic               flip;

   // Capture the transfer and look up the unit constant.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
      end
      if (accept) begin
         ang0_ff <= angle;
         x0_ff   <= x_in;
         y0_ff   <= y_in;
         err0_ff <= (unit >= 4'(UNIT_COUNT));
         k0_ff   <= (unit >= 4'(UNIT_COUNT)) ? '0 : UNIT_K[unit];
      end
   end

   // Angle times unit constant as eight 24 by 32 partial products.
   always_comb begin
      logic [23:0]        al;
      logic signed [23:0] ah;
      logic [31:0]        kj;
      logic [55:0]        tl;
      logic signed [56:0] th;
      al = ang0_ff[23:0];
      ah = ang0_ff[47:24];
      for (int j = 0; j < 4; j++) begin
         kj = k0_ff[32 * j +: 32];
         tl = 56'(al) * 56'(kj);
         th = ah * $signed({1'b0, kj});
         pp_in[2 * j]     = 128'(tl) << (32 * j);
         pp_in[2 * j + 1] = {{71{th[56]}}, th} << (24 + 32 * j);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      pp_ff   <= pp_in;
      xp1_ff  <= x0_ff * $signed({1'b0, INV_GAIN});
      yp1_ff  <= y0_ff * $signed({1'b0, INV_GAIN});
      err1_ff <= err0_ff;
   end

   // Adder tree; the point is brought to its working scale alongside.
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      for (int j = 0; j < 4; j++) begin
         sum4_ff[j] <= pp_ff[2 * j] + pp_ff[2 * j + 1];
      end
      x2_ff      <= xp1_ff >>> 8;
      y2_ff      <= yp1_ff >>> 8;
      err2_ff    <= err1_ff;
      sum2_ff[0] <= sum4_ff[0] + sum4_ff[1];
      sum2_ff[1] <= sum4_ff[2] + sum4_ff[3];
      x3_ff      <= x2_ff;
      y3_ff      <= y2_ff;
      err3_ff    <= err2_ff;
   end

   // Upper product word rounded to the phase resolution.
   assign prod      = sum2_ff[0] + sum2_ff[1];
   assign phase_rnd = (prod[127:64] + PHASE_HALF) & PHASE_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      z4_ff   <= phase_rnd;
      x4_ff   <= x3_ff;
      y4_ff   <= y3_ff;
      err4_ff <= err3_ff;
   end

   // Second and third quadrants: negate the point and add half a turn.
   assign flip = (z4_ff[63] != z4_ff[62]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      item_ff.x   <= flip ? -x4_ff : x4_ff;
      item_ff.y   <= flip ? -y4_ff : y4_ff;
      item_ff.z   <= {z4_ff[63] ^ flip, z4_ff[62:0]};
      item_ff.err <= err4_ff;
   end

   assign push = v5_ff;
   assign item = item_ff;

endmodule

@@ rtl/rxya_queue.sv @@
`timescale 1ns / 1ps
module rxya_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rxya_pkg::item_type   push_item,
   output logic                 pop,
   output rxya_pkg::item_type   pop_item,
   output logic                 full
);
   import rxya_pkg::*;

   localparam int DEPTH = 4;

   item_type   mem_ff [DEPTH];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff, count_in;

   // The rotation pipeline never stalls, so it takes an entry whenever one waits.
   assign pop      = (count_ff != 3'd0);
   assign full     = (count_ff == 3'(DEPTH));
   assign pop_item = mem_ff[rd_ptr_ff];
   assign count_in = count_ff + 3'(push) - 3'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + 2'(push);
         rd_ptr_ff <= rd_ptr_ff + 2'(pop);
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/rxya_back.sv @@
`timescale 1ns / 1ps
module rxya_back #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  rxya_pkg::item_type   item,
   output logic                 rsp_valid,
   output logic signed [31:0]   rsp_x_out,
   output logic signed [31:0]   rsp_y_out,
   output logic                 rsp_unit_error,
   output logic                 rsp_saturated
);
   import rxya_pkg::*;

   logic               v_ff   [CORDIC_STAGES + 1];
   logic signed [63:0] x_ff   [CORDIC_STAGES + 1];
   logic signed [63:0] y_ff   [CORDIC_STAGES + 1];
   logic [63:0]        z_ff   [CORDIC_STAGES + 1];
   logic               err_ff [CORDIC_STAGES + 1];

   // Entry register of the rotation pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= take;
      end
      x_ff[0]   <= item.x;
      y_ff[0]   <= item.y;
      z_ff[0]   <= item.z;
      err_ff[0] <= item.err;
   end

   // One micro-rotation per stage, direction from the sign of the residual phase.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      localparam logic [63:0] STEP = atan_turns(i);
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i + 1] <= 1'b0;
         end else begin
            v_ff[i + 1] <= v_ff[i];
         end
         if (!z_ff[i][63]) begin
            x_ff[i + 1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i + 1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i + 1] <= z_ff[i] - STEP;
         end else begin
            x_ff[i + 1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i + 1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i + 1] <= z_ff[i] + STEP;
         end
         err_ff[i + 1] <= err_ff[i];
      end
   end

   // Round away the guard bits and clip to Q16.16.
   logic signed [63:0] xr, yr;
   logic signed [39:0] xs, ys;
   logic               x_hi, x_lo, y_hi, y_lo;
   logic signed [31:0] x_sat, y_sat;

   assign xr   = x_ff[CORDIC_STAGES] + 64'sd8388608;
   assign yr   = y_ff[CORDIC_STAGES] + 64'sd8388608;
   assign xs   = 40'(xr >>> 24);
   assign ys   = 40'(yr >>> 24);
   assign x_hi = (xs > 40'sd2147483647);
   assign x_lo = (xs < -40'sd2147483648);
   assign y_hi = (ys > 40'sd2147483647);
   assign y_lo = (ys < -40'sd2147483648);

   always_comb begin
      x_sat = xs[31:0];
      y_sat = ys[31:0];
      if (x_hi) x_sat = 32'sh7FFF_FFFF;
      if (x_lo) x_sat = 32'sh8000_0000;
      if (y_hi) y_sat = 32'sh7FFF_FFFF;
      if (y_lo) y_sat = 32'sh8000_0000;
   end

   // Result register; an invalid unit gives zeros and the error flag.
   logic               valid_ff;
   logic signed [31:0] x_out_ff, y_out_ff;
   logic               err_out_ff, sat_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= v_ff[CORDIC_STAGES];
      end
      x_out_ff   <= err_ff[CORDIC_STAGES] ? '0 : x_sat;
      y_out_ff   <= err_ff[CORDIC_STAGES] ? '0 : y_sat;
      err_out_ff <= err_ff[CORDIC_STAGES];
      sat_out_ff <= !err_ff[CORDIC_STAGES] && (x_hi || x_lo || y_hi || y_lo);
   end

   assign rsp_valid      = valid_ff;
   assign rsp_x_out      = x_out_ff;
   assign rsp_y_out      = y_out_ff;
   assign rsp_unit_error = err_out_ff;
   assign rsp_saturated  = sat_out_ff;

endmodule

@@ rtl/rotate_xy_by_angle_with_units.sv @@
`timescale 1ns / 1ps
// Rotates a Q16.16 point by a Q32.16 angle given in one of fourteen angle units and
// returns the rotated point, saturated to Q16.16. A new point is taken in every
// clock cycle (start while busy is low); each result is shown on rsp_valid for a
// single cycle and must be taken then, since the block cannot hold results.
// The front end (six stages: unit constant lookup, 24 by 32 partial products,
// a two-level adder tree, phase rounding and quadrant fold) feeds a four-entry
// queue that the unrolled CORDIC pipeline, one stage per micro-rotation, drains
// every cycle, so busy stays low in normal use.
// An invalid unit code yields zero coordinates with rsp_unit_error set.
module rotate_xy_by_angle_with_units #(
   parameter int CORDIC_STAGES = 24,
   parameter int PHASE_BITS    = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_x_in,
   input  logic signed [31:0] req_y_in,
   input  logic signed [47:0] req_angle,
   input  logic [3:0]         req_unit,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_x_out,
   output logic signed [31:0] rsp_y_out,
   output logic               rsp_unit_error,
   output logic               rsp_saturated
);
   import rxya_pkg::*;

   logic     accept;
   logic     push, pop, full;
   item_type push_item, pop_item;

   // A transfer completes when start is high and the queue has room.
   assign busy   = full;
   assign accept = start && !busy;

   rxya_front #(
      .CORDIC_STAGES (CORDIC_STAGES),
      .PHASE_BITS    (PHASE_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .x_in   (req_x_in),
      .y_in   (req_y_in),
      .angle  (req_angle),
      .unit   (req_unit),
      .push   (push),
      .item   (push_item)
   );

   rxya_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (full)
   );

   rxya_back #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .take           (pop),
      .item           (pop_item),
      .rsp_valid      (rsp_valid),
      .rsp_x_out      (rsp_x_out),
      .rsp_y_out      (rsp_y_out),
      .rsp_unit_error (rsp_unit_error),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

@@ tb/rotate_xy_by_angle_with_units_tb.sv @@
`timescale 1ns / 1ps
module rotate_xy_by_angle_with_units_tb;

   localparam int STAGES     = 24;
   localparam int PHASE_BITS = 32;
   localparam int GUARD      = 24;
   localparam int LATENCY    = STAGES + 8;
   localparam int RAND_ITEMS = 830;

   // Plane-angle unit codes; the last two are not recognized.
   typedef enum logic [3:0] {
      U_RAD, U_MILLISECA, U_CCGR, U_CGR, U_DEGA, U_GON, U_KRAD,
      U_MILA, U_MINA, U_MEGARAD, U_MRAD, U_REV, U_SECA, U_URAD,
      U_BAD_A, U_BAD_B
   } unit_code_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               unit_error;
      logic               saturated;
   } rotated_point_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_x_in;
   logic signed [31:0] req_y_in;
   logic signed [47:0] req_angle;
   logic [3:0]         req_unit;
   logic               rsp_valid;
   logic signed [31:0] rsp_x_out;
   logic signed [31:0] rsp_y_out;
   logic               rsp_unit_error;
   logic               rsp_saturated;

   rotated_point_type pending_points[$];
   int                fail_count = 0;

   // Per-unit turn fraction, micro-rotation angles and inverse gain.
   logic [127:0] turn_per_lsb [14];
   logic [63:0]  micro_angle [STAGES];
   logic [63:0]  inv_gain_q32;

   rotate_xy_by_angle_with_units dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_x_in       (req_x_in),
      .req_y_in       (req_y_in),
      .req_angle      (req_angle),
      .req_unit       (req_unit),
      .rsp_valid      (rsp_valid),
      .rsp_x_out      (rsp_x_out),
      .rsp_y_out      (rsp_y_out),
      .rsp_unit_error (rsp_unit_error),
      .rsp_saturated  (rsp_saturated)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Fill the unit constants, the atan table and the inverse gain.
   task automatic build_tables();
      logic [31:0]  mul_tab [14];
      logic [31:0]  div_tab [14];
      logic         rad_tab [14];
      logic [255:0] num;
      logic [255:0] quo;
      logic [63:0]  sum;
      logic [63:0]  term;
      logic [127:0] prod;
      logic [63:0]  g;
      logic [63:0]  t;
      logic [63:0]  c;
      mul_tab = '{1, 1, 1, 1, 1, 1, 1000, 1, 1, 1000000, 1, 1, 1, 1};
      div_tab = '{1, 1296000000, 4000000, 40000, 360, 400, 1,
                  6400, 21600, 1, 1000, 1, 1296000, 1000000};
      rad_tab = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                  1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
      for (int u = 0; u < 14; u++) begin
         if (rad_tab[u]) begin
            num = 256'h28BE60DB9391054A7F09D5F47D4D377036D8A5664F10E410 * 256'(mul_tab[u]);
         end else begin
            num = 256'(mul_tab[u]) << 192;
         end
         quo = num / 256'(div_tab[u]);
         turn_per_lsb[u] = quo[207:80] + 128'(quo[79]);
      end
      // atan(2^-i) in turns: Taylor series in Q0.64 scaled by 1/(2*pi).
      micro_angle[0] = 64'h2000_0000_0000_0000;
      for (int i = 1; i < STAGES; i++) begin
         sum = '0;
         for (int k = 0; i * (2 * k + 1) < 64; k++) begin
            term = (64'd1 << (64 - i * (2 * k + 1))) / 64'(2 * k + 1);
            sum = (k % 2 == 1) ? sum - term : sum + term;
         end
         prod = 128'(sum) * 128'(64'h28BE60DB9391054A);
         micro_angle[i] = prod[127:64];
      end
      // Largest c with c^2 * gain^2 below one, found bit by bit.
      g = 64'd1 << 62;
      for (int i = 0; i < STAGES; i++) begin
         g = g + (g >> (2 * i));
      end
      c = '0;
      for (int b = 31; b >= 0; b--) begin
         t = c | (64'd1 << b);
         prod = 128'(t * t) * 128'(g);
         if (prod[127:64] < (64'd1 << 62)) begin
            c = t;
         end
      end
      inv_gain_q32 = c;
   endtask

   // Round a guard-bit value back to Q16.16 and clip it.
   function automatic logic signed [31:0] round_clip(input longint w, inout logic clipped);
      longint r;
      r = (w + (longint'(1) << (GUARD - 1))) >>> GUARD;
      if (r > 64'sd2147483647) begin
         r = 64'sd2147483647;
         clipped = 1'b1;
      end
      if (r < -64'sd2147483648) begin
         r = -64'sd2147483648;
         clipped = 1'b1;
      end
      return r[31:0];
   endfunction

   // Expected rotation of one point.
   function automatic rotated_point_type rotate_point(input logic signed [31:0] xi,
                                                      input logic signed [31:0] yi,
                                                      input logic signed [47:0] ang,
                                                      input logic [3:0] unit);
      rotated_point_type res;
      logic [127:0]      turns;
      logic [63:0]       z;
      longint            x;
      longint            y;
      longint            dx;
      longint            dy;
      logic              clipped;
      res = '{0, 0, 1'b0, 1'b0};
      clipped = 1'b0;
      if (unit >= 4'(U_BAD_A)) begin
         res.unit_error = 1'b1;
         return res;
      end
      // Phase: angle times turns per LSB, modulo one turn, rounded.
      turns = {{80{ang[47]}}, ang} * turn_per_lsb[unit];
      z = (turns[127:64] + (64'd1 << (63 - PHASE_BITS)))
          & ~((64'd1 << (64 - PHASE_BITS)) - 64'd1);
      x = (longint'(xi) * longint'(inv_gain_q32)) >>> 8;
      y = (longint'(yi) * longint'(inv_gain_q32)) >>> 8;
      // Fold the second and third quadrants into the first and fourth.
      if (z[63:62] == 2'b01 || z[63:62] == 2'b10) begin
         x = -x;
         y = -y;
         z = z + (64'd1 << 63);
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (!z[63]) begin
            x = x - dx;
            y = y + dy;
            z = z - micro_angle[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + micro_angle[i];
         end
      end
      res.x = round_clip(x, clipped);
      res.y = round_clip(y, clipped);
      res.saturated = clipped;
      return res;
   endfunction

   // Send one point after a random gap; start stays high for back-to-back transfers.
   task automatic send_point(input logic signed [31:0] xi, input logic signed [31:0] yi,
                             input logic signed [47:0] ang, input logic [3:0] unit);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) begin
         gap = 0;
      end
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start     <= 1'b1;
      req_x_in  <= xi;
      req_y_in  <= yi;
      req_angle <= ang;
      req_unit  <= unit;
      do begin
         @(posedge clock);
      end while (busy);
      pending_points.push_back(rotate_point(xi, yi, ang, unit));
   endtask

   // Drop start and wait until every expected result has arrived.
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_points.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Check each result transfer against the oldest expectation.
   always @(posedge clock) begin
      rotated_point_type exp_pt;
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            $error("unexpected result x_out=%h y_out=%h", rsp_x_out, rsp_y_out);
            fail_count++;
         end else begin
            exp_pt = pending_points.pop_front();
            if (rsp_x_out !== exp_pt.x) begin
               $error("x_out: expected %h, got %h", exp_pt.x, rsp_x_out);
               fail_count++;
            end
            if (rsp_y_out !== exp_pt.y) begin
               $error("y_out: expected %h, got %h", exp_pt.y, rsp_y_out);
               fail_count++;
            end
            if (rsp_unit_error !== exp_pt.unit_error) begin
               $error("unit_error: expected %b, got %b", exp_pt.unit_error, rsp_unit_error);
               fail_count++;
            end
            if (rsp_saturated !== exp_pt.saturated) begin
               $error("saturated: expected %b, got %b", exp_pt.saturated, rsp_saturated);
               fail_count++;
            end
         end
      end
   end

   // Every unit code, the two invalid ones included.
   task automatic test_all_units();
      for (int u = 0; u < 16; u++) begin
         send_point(32'sh0001_0000, 32'sh0000_8000, 48'sh0000_002D_0000, 4'(u));
      end
   endtask

   // Field extremes, huge wrapping angles and clipped results.
   task automatic test_extremes();
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 48'sh0000_002D_0000, U_DEGA);
      send_point(32'sh8000_0000, 32'sh8000_0000, 48'sh0000_0087_0000, U_DEGA);
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 48'sh7FFF_FFFF_FFFF, U_URAD);
      send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 48'sh8000_0000_0000, U_MEGARAD);
      send_point(32'sh0000_0000, 32'sh0000_0000, 48'sh8000_0000_0000, U_RAD);
      send_point(32'sh0001_0000, 32'sh0000_0000, 48'shFFFF_FFFF_FFFF, U_REV);
      send_point(32'sh0001_0000, 32'shFFFF_0000, 48'sh0000_0000_8000, U_REV);
      send_point(32'sh7FFF_FFFF, 32'sh0000_0000, 48'sh0000_00B4_0000, U_DEGA);
      send_point(32'sh8000_0000, 32'sh0000_0000, 48'sh0000_00B4_0000, U_DEGA);
   endtask

   // Pause the sender until the pipeline is empty, then resume.
   task automatic test_drain_pause();
      drain_results();
      repeat (4) begin
         send_point($urandom, $urandom, 48'sh0000_005A_0000, U_DEGA);
      end
      drain_results();
   endtask

   // Random points, mostly sane values with a share of full-range noise.
   task automatic test_random_points();
      logic signed [31:0] xi;
      logic signed [31:0] yi;
      logic signed [47:0] ang;
      logic [3:0]         unit;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         xi  = $urandom;
         yi  = $urandom;
         ang = 48'({$urandom, $urandom});
         if ($urandom_range(0, 2) != 0) begin
            xi = xi >>> $urandom_range(0, 14);
            yi = yi >>> $urandom_range(0, 14);
         end
         if ($urandom_range(0, 1) == 0) begin
            ang = ang >>> $urandom_range(16, 40);
         end
         unit = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(14, 15))
                                            : 4'($urandom_range(0, 13));
         if ($urandom_range(0, 3) == 0) begin
            ang = ang >>> 8;
         end
         send_point(xi, yi, ang, unit);
         if (n % 200 == 199) begin
            drain_results();
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_x_in  = '0;
      req_y_in  = '0;
      req_angle = '0;
      req_unit  = '0;
      build_tables();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_all_units();
      test_extremes();
      test_drain_pause();
      test_random_points();

      drain_results();
      repeat (LATENCY + 8) @(posedge clock);
      if (fail_count == 0 && pending_points.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Safety net against a hung handshake.
   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
